// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TCF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define TCF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define TCF_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/tcf_pkg.sv -----
// Types and constants shared by the telnet command filter modules.
package tcf_pkg;

   localparam logic [7:0] BYTE_SE   = 8'd240;
   localparam logic [7:0] BYTE_SB   = 8'd250;
   localparam logic [7:0] BYTE_WILL = 8'd251;
   localparam logic [7:0] BYTE_DONT = 8'd254;
   localparam logic [7:0] BYTE_IAC  = 8'd255;

   localparam logic [2:0] KIND_DATA        = 3'd0;
   localparam logic [2:0] KIND_ABSORBED    = 3'd1;
   localparam logic [2:0] KIND_COMMAND     = 3'd2;
   localparam logic [2:0] KIND_NEGOTIATION = 3'd3;
   localparam logic [2:0] KIND_SUBNEG      = 3'd4;

   typedef enum logic [2:0] {
      PS_NORMAL  = 3'd0,
      PS_IAC     = 3'd1,
      PS_VERB    = 3'd2,
      PS_SB      = 3'd3,
      PS_PAYLOAD = 3'd4,
      PS_PAYIAC  = 3'd5
   } parse_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [1:0] request;
      logic [7:0] sub_id;
      logic [6:0] sub_length;
      logic       overflow;
      logic       last;
   } result_type;

   typedef struct packed {
      logic store_write;
      logic replay_start;
   } parse_ctl_type;

endpackage

// ----- rtl/core/telnet_command_filter.sv -----
// Telnet command filter top level: parser, payload memory and a registered result stage.
// A single result is shown in the cycle after the transfer of its byte; throughput is one
// byte per cycle while the result side keeps up and no replay is running.
// IAC SE with N stored bytes replays them from the memory through the read register and the
// output register, one per cycle while the result side keeps up, with the input closed until the last byte is taken.
// Reset is synchronous; it clears the parse state and the result valid flag, not the memory.
module telnet_command_filter #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_request,
   output logic [7:0] rsp_sub_id,
   output logic [6:0] rsp_sub_length,
   output logic       rsp_overflow,
   output logic       rsp_last
);

   import tcf_pkg::*;

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

   result_type    single_res;
   parse_ctl_type ctl;
   logic [CW-1:0] count;
   logic [7:0]    option_id;
   logic          dropped;
   logic [7:0]    rd_data;

   logic          accept;
   logic          load_ok;
   logic          consume;
   logic          issue;

   logic          replay_ff, replay_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] iss_idx_ff, iss_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    out_ff, out_in;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !replay_ff && load_ok;
   assign accept    = req_valid && req_ready;

   // A replayed byte leaves the read register when the output register is free.
   assign consume = replay_ff && pend_ff && load_ok;
   assign issue   = replay_ff && (iss_idx_ff < count) && (!pend_ff || consume);

   tcf_parser #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
      .CW           (CW)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stream_byte  (req_stream_byte),
      .result       (single_res),
      .ctl          (ctl),
      .payload_count(count),
      .option_id    (option_id),
      .dropped      (dropped)
   );

   tcf_payload_ram #(
      .DEPTH(PAYLOAD_DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (accept && ctl.store_write),
      .wr_addr(count[AW-1:0]),
      .wr_data(req_stream_byte),
      .rd_en  (issue),
      .rd_addr(iss_idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      replay_in    = replay_ff;
      pend_in      = pend_ff;
      iss_idx_in   = iss_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (accept) begin
         if (ctl.replay_start) begin
            replay_in  = 1'b1;
            pend_in    = 1'b0;
            iss_idx_in = '0;
         end else begin
            rsp_valid_in = 1'b1;
            out_in       = single_res;
         end
      end
      if (consume) begin
         rsp_valid_in      = 1'b1;
         out_in.kind       = KIND_SUBNEG;
         out_in.value      = rd_data;
         out_in.request    = '0;
         out_in.sub_id     = option_id;
         out_in.sub_length = 7'(count);
         out_in.overflow   = dropped;
         // The pending byte is the final one once every index has been issued.
         out_in.last       = (iss_idx_ff == count);
         pend_in           = 1'b0;
         if (iss_idx_ff == count) begin
            replay_in = 1'b0;
         end
      end
      if (issue) begin
         pend_in    = 1'b1;
         iss_idx_in = iss_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replay_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         iss_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         replay_ff    <= replay_in;
         pend_ff      <= pend_in;
         iss_idx_ff   <= iss_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_value      = out_ff.value;
   assign rsp_request    = out_ff.request;
   assign rsp_sub_id     = out_ff.sub_id;
   assign rsp_sub_length = out_ff.sub_length;
   assign rsp_overflow   = out_ff.overflow;
   assign rsp_last       = out_ff.last;

endmodule

// ----- rtl/core/tcf_payload_ram.sv -----
// Single-port-write, single-port-read payload memory with registered read data.
module tcf_payload_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tcf_parser.sv -----
// Byte classifier and parse state registers of the telnet command filter.
module tcf_parser #(
   parameter int PAYLOAD_DEPTH = 64,
   parameter int CW            = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             stream_byte,
   output tcf_pkg::result_type    result,
   output tcf_pkg::parse_ctl_type ctl,
   output logic [CW-1:0]          payload_count,
   output logic [7:0]             option_id,
   output logic                   dropped
);

   import tcf_pkg::*;

   localparam logic [CW-1:0] DEPTH_C = CW'(PAYLOAD_DEPTH);

   parse_state_type state_ff, state_in;
   logic [1:0]      pend_req_ff, pend_req_in;
   logic [7:0]      option_ff, option_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            dropped_ff, dropped_in;

   logic is_verb;
   logic has_room;
   logic store;
   logic clear_payload;

   assign is_verb  = (stream_byte >= BYTE_WILL) && (stream_byte <= BYTE_DONT);
   assign has_room = count_ff < DEPTH_C;

   // Next parse state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PS_IAC: begin
            if (is_verb) begin
               state_in = PS_VERB;
            end else if (stream_byte == BYTE_SB) begin
               state_in = PS_SB;
            end else begin
               state_in = PS_NORMAL;
            end
         end
         PS_VERB:    state_in = PS_NORMAL;
         PS_SB:      state_in = PS_PAYLOAD;
         PS_PAYLOAD: state_in = (stream_byte == BYTE_IAC) ? PS_PAYIAC : PS_PAYLOAD;
         PS_PAYIAC:  state_in = (stream_byte == BYTE_SE) ? PS_NORMAL : PS_PAYLOAD;
         default:    state_in = (stream_byte == BYTE_IAC) ? PS_IAC : PS_NORMAL;
      endcase
   end

   // Result and control outputs for the byte on the input.
   always_comb begin
      result        = '0;
      result.kind   = KIND_ABSORBED;
      result.value  = stream_byte;
      result.last   = 1'b1;
      store         = 1'b0;
      clear_payload = 1'b0;
      ctl           = '0;
      unique case (state_ff)
         PS_IAC: begin
            if (stream_byte == BYTE_IAC) begin
               result.kind = KIND_DATA;
            end else if (!is_verb && stream_byte != BYTE_SB) begin
               result.kind = KIND_COMMAND;
            end
         end
         PS_VERB: begin
            result.kind    = KIND_NEGOTIATION;
            result.request = pend_req_ff;
         end
         PS_SB: begin
            clear_payload = 1'b1;
         end
         PS_PAYLOAD: begin
            store = (stream_byte != BYTE_IAC);
         end
         PS_PAYIAC: begin
            if (stream_byte != BYTE_SE) begin
               store = 1'b1;
            end else if (count_ff == '0) begin
               // An empty subnegotiation still reports one result.
               result.kind     = KIND_SUBNEG;
               result.value    = '0;
               result.sub_id   = option_ff;
               result.overflow = dropped_ff;
            end else begin
               ctl.replay_start = 1'b1;
            end
         end
         default: begin
            if (stream_byte != BYTE_IAC) begin
               result.kind = KIND_DATA;
            end
         end
      endcase
      ctl.store_write = store && has_room;
   end

   // Next values of the parse registers.
   always_comb begin
      pend_req_in = pend_req_ff;
      option_in   = option_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      if (state_ff == PS_IAC && is_verb) begin
         pend_req_in = 2'(stream_byte - BYTE_WILL);
      end
      if (clear_payload) begin
         option_in  = stream_byte;
         count_in   = '0;
         dropped_in = 1'b0;
      end
      if (store) begin
         if (has_room) begin
            count_in = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PS_NORMAL;
         pend_req_ff <= '0;
         option_ff   <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else if (accept) begin
         state_ff    <= state_in;
         pend_req_ff <= pend_req_in;
         option_ff   <= option_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
      end
   end

   assign payload_count = count_ff;
   assign option_id     = option_ff;
   assign dropped       = dropped_ff;

endmodule

// ----- rtl/core/tcf_checker.sv -----
// Port-level checker for the telnet command filter, bound to the top level.
`include "assert_macros.svh"

module tcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_stream_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_value,
   input logic [1:0] rsp_request,
   input logic [7:0] rsp_sub_id,
   input logic [6:0] rsp_sub_length,
   input logic       rsp_overflow,
   input logic       rsp_last
);

   import tcf_pkg::*;

   // A stalled result holds its contents until the transfer.
   `TCF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_last))

   // No byte is taken while a result is stalled at the output.
   `TCF_ASSERT_IMP(a_no_take_on_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // Only subnegotiation payload results can come in a group.
   `TCF_ASSERT_IMP(a_single_last, clock, reset, rsp_valid && rsp_kind != KIND_SUBNEG, rsp_last)

   // Subnegotiation fields are zero on every other kind of result.
   `TCF_ASSERT_IMP(a_sub_fields_zero, clock, reset, rsp_valid && rsp_kind != KIND_SUBNEG, rsp_sub_id == 8'd0 && rsp_sub_length == 7'd0 && !rsp_overflow)

   // The output register is empty straight after reset.
   `TCF_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind telnet_command_filter tcf_checker u_checker (.*);

// ----- verif/telnet_command_filter_test.sv -----
// Self-checking testbench for the telnet command filter: byte stream in, parsed results out.
module telnet_command_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tcf_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int PAYLOAD_DEPTH = 64;
   localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_BYTES   = 16;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [7:0] BYTE_WONT         = 8'd252;
   localparam logic [7:0] BYTE_DO           = 8'd253;
   localparam logic [7:0] CMD_NOP           = 8'd241;
   localparam logic [7:0] OPT_BINARY        = 8'd0;
   localparam logic [7:0] OPT_TERMINAL_TYPE = 8'd24;
   localparam logic [7:0] OPT_WINDOW_SIZE   = 8'd31;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_stream_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic [1:0] rsp_request;
   logic [7:0] rsp_sub_id;
   logic [6:0] rsp_sub_length;
   logic       rsp_overflow;
   logic       rsp_last;

   telnet_command_filter #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_value(rsp_value),
      .rsp_request(rsp_request),
      .rsp_sub_id(rsp_sub_id),
      .rsp_sub_length(rsp_sub_length),
      .rsp_overflow(rsp_overflow),
      .rsp_last(rsp_last)
   );

   // Parser state as the testbench expects it to be.
   parse_state_type filter_state = PS_NORMAL;
   logic [1:0]      verb_code = 2'd0;
   logic [7:0]      sub_option = 8'd0;
   logic [7:0]      payload_bytes [PAYLOAD_DEPTH];
   int unsigned     stored_count = 0;
   logic            payload_dropped = 1'b0;

   result_type  expected_results [$];
   logic [7:0]  pending_bytes [$];
   int unsigned bytes_queued = 0;
   int unsigned bytes_offered = 0;
   int unsigned bytes_accepted = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned command_results = 0;
   int unsigned negotiation_results = 0;
   int unsigned subneg_results = 0;
   int unsigned overflow_results = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic void store_payload(logic [7:0] b);
      if (stored_count < PAYLOAD_DEPTH) begin
         payload_bytes[PAYLOAD_AW'(stored_count)] = b;
         stored_count++;
      end else begin
         payload_dropped = 1'b1;
      end
   endfunction

   function automatic void expect_result(result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Works out the results that one accepted stream byte should produce.
   function automatic void predict_results(logic [7:0] b);
      result_type r;
      r = '0;
      r.kind = KIND_ABSORBED;
      r.value = b;
      r.last = 1'b1;
      case (filter_state)
         PS_IAC: begin
            if (b == BYTE_IAC) begin
               filter_state = PS_NORMAL;
               r.kind = KIND_DATA;
            end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
               verb_code = 2'(b - BYTE_WILL);
               filter_state = PS_VERB;
            end else if (b == BYTE_SB) begin
               filter_state = PS_SB;
            end else begin
               filter_state = PS_NORMAL;
               r.kind = KIND_COMMAND;
            end
            expect_result(r);
         end
         PS_VERB: begin
            filter_state = PS_NORMAL;
            r.kind = KIND_NEGOTIATION;
            r.request = verb_code;
            expect_result(r);
         end
         PS_SB: begin
            sub_option = b;
            stored_count = 0;
            payload_dropped = 1'b0;
            filter_state = PS_PAYLOAD;
            expect_result(r);
         end
         PS_PAYLOAD: begin
            if (b == BYTE_IAC) filter_state = PS_PAYIAC;
            else store_payload(b);
            expect_result(r);
         end
         PS_PAYIAC: begin
            if (b != BYTE_SE) begin
               store_payload(b);
               filter_state = PS_PAYLOAD;
               expect_result(r);
            end else begin
               // IAC SE replays the whole stored payload, or one empty result.
               filter_state = PS_NORMAL;
               r.kind = KIND_SUBNEG;
               r.sub_id = sub_option;
               r.overflow = payload_dropped;
               if (stored_count == 0) begin
                  r.value = 8'd0;
                  expect_result(r);
               end else begin
                  r.sub_length = 7'(stored_count);
                  for (int unsigned k = 0; k < stored_count; k++) begin
                     r.value = payload_bytes[PAYLOAD_AW'(k)];
                     r.last = (k + 1 == stored_count);
                     expect_result(r);
                  end
               end
            end
         end
         default: begin
            if (b == BYTE_IAC) filter_state = PS_IAC;
            else begin
               filter_state = PS_NORMAL;
               r.kind = KIND_DATA;
            end
            expect_result(r);
         end
      endcase
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Receiver hold-off, counted here so that it runs regardless of the random stalls.
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   // Driver: a new byte is offered only once the previous transfer has completed.
   always @(negedge clock) begin
      if (!reset) begin
         if (bytes_offered == bytes_accepted) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_stream_byte <= pending_bytes.pop_front();
               bytes_offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: predicts on each input transfer and checks each result transfer.
   always @(posedge clock) begin
      result_type want;
      if (!reset && req_valid && req_ready) begin
         predict_results(req_stream_byte);
         bytes_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no expectation: kind %0d value %0d", rsp_kind, rsp_value);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("value", 32'(want.value), 32'(rsp_value));
            check_field("request", 32'(want.request), 32'(rsp_request));
            check_field("sub_id", 32'(want.sub_id), 32'(rsp_sub_id));
            check_field("sub_length", 32'(want.sub_length), 32'(rsp_sub_length));
            check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            check_field("last", 32'(want.last), 32'(rsp_last));
            results_checked++;
            if (want.kind == KIND_COMMAND) command_results++;
            if (want.kind == KIND_NEGOTIATION) negotiation_results++;
            if (want.kind == KIND_SUBNEG) subneg_results++;
            if (want.overflow) overflow_results++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** telnet_command_filter: FAILED **");
         $finish;
      end
   end

   function automatic void offer_byte(logic [7:0] b);
      pending_bytes.insert(pending_bytes.size(), b);
      bytes_queued++;
   endfunction

   // Well-formed subnegotiation storing the given number of random payload bytes.
   function automatic void add_subnegotiation(int unsigned stored);
      logic [7:0] b;
      offer_byte(BYTE_IAC);
      offer_byte(BYTE_SB);
      offer_byte(8'($urandom_range(255)));
      repeat (stored) begin
         b = ($urandom_range(7) == 0) ? BYTE_IAC : 8'($urandom_range(255));
         if (b == BYTE_IAC) begin
            offer_byte(BYTE_IAC);
            offer_byte(BYTE_IAC);
         end else if (b != BYTE_SE && $urandom_range(9) == 0) begin
            offer_byte(BYTE_IAC);
            offer_byte(b);
         end else begin
            offer_byte(b);
         end
      end
      offer_byte(BYTE_IAC);
      offer_byte(BYTE_SE);
   endfunction

   function automatic void add_random_sequence();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         offer_byte(8'($urandom_range(254)));
      end else if (pick < 33) begin
         offer_byte(BYTE_IAC);
         offer_byte(BYTE_IAC);
      end else if (pick < 45) begin
         offer_byte(BYTE_IAC);
         offer_byte(8'($urandom_range(249)));
      end else if (pick < 65) begin
         offer_byte(BYTE_IAC);
         offer_byte(8'($urandom_range(BYTE_WILL, BYTE_DONT)));
         offer_byte(8'($urandom_range(255)));
      end else if (pick < 88) begin
         add_subnegotiation(($urandom_range(4) == 0) ? $urandom_range(24) : $urandom_range(6));
      end else begin
         // Noise, sometimes an opened subnegotiation that is never properly closed.
         if ($urandom_range(1) == 0) begin
            offer_byte(BYTE_IAC);
            offer_byte(BYTE_SB);
         end
         repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(255)));
      end
   endfunction

   task automatic wait_until_drained();
      do @(negedge clock);
      while (bytes_accepted != bytes_queued || expected_results.size() != 0);
   endtask

   initial begin
      int unsigned phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: plain data, escaped IAC, a command, every verb, empty and escaped payloads.
      offer_byte(8'd0);
      offer_byte(BYTE_IAC); offer_byte(BYTE_IAC);
      offer_byte(BYTE_IAC); offer_byte(CMD_NOP);
      offer_byte(BYTE_IAC); offer_byte(BYTE_WILL); offer_byte(OPT_BINARY);
      offer_byte(BYTE_IAC); offer_byte(BYTE_WONT); offer_byte(8'd255);
      offer_byte(BYTE_IAC); offer_byte(BYTE_DO);   offer_byte(OPT_TERMINAL_TYPE);
      offer_byte(BYTE_IAC); offer_byte(BYTE_DONT); offer_byte(OPT_WINDOW_SIZE);
      offer_byte(BYTE_IAC); offer_byte(BYTE_SB); offer_byte(OPT_TERMINAL_TYPE);
      offer_byte(BYTE_IAC); offer_byte(BYTE_SE);
      offer_byte(BYTE_IAC); offer_byte(BYTE_SB); offer_byte(OPT_WINDOW_SIZE);
      offer_byte(BYTE_IAC); offer_byte(BYTE_IAC); offer_byte(BYTE_IAC); offer_byte(BYTE_SE);
      wait_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         phase_start = bytes_queued;
         // A payload that overruns the store and sets the overflow flag.
         if (phase == 2) add_subnegotiation(PAYLOAD_DEPTH + 6);
         while (bytes_queued - phase_start < PHASE_BYTES)
            add_random_sequence();
         if (phase == 0) hold_requests++;
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d stream bytes and %0d results under four idling patterns:",
               bytes_accepted, results_checked);
      $display("%0d commands, %0d negotiations, %0d payload results (%0d with overflow).",
               command_results, negotiation_results, subneg_results, overflow_results);
      if (error_count == 0) begin
         $display("** telnet_command_filter: PASSED **");
      end else begin
         $display("** telnet_command_filter: FAILED **");
      end
      $finish;
   end

endmodule
